[src/rdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants of the radix digit converter
// Field widths, symbol codes, back-end states, the queued item and the
// reciprocal table used to divide by the radix.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int WHOLE_W     = 30;
    localparam int FRAC_W      = 32;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int KIND_W      = 2;
    localparam int RECIP_W     = 32;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 8;

    localparam int FRACTION_DIGITS_DEF  = 6;
    localparam int WHOLE_DIGITS_MAX_DEF = 30;

    // Queue between front and back; keep it a power of two.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

    typedef enum logic [KIND_W-1:0] {
        KIND_MINUS = 2'd0,
        KIND_DIGIT = 2'd1,
        KIND_POINT = 2'd2
    } symbol_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_MUL,
        ST_FIX,
        ST_POP,
        ST_POINT,
        ST_FRAC
    } back_state_t;

    typedef struct packed {
        logic                  neg;
        logic [WHOLE_W-1:0]    whole;
        logic [FRAC_W-1:0]     frac;
        logic [RADIX_W-1:0]    base;
        logic                  frac_nz;
    } rdc_item_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    // floor(2^32 / base); the quotient estimate is then exact or one low.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [RADIX_W-1:0] base);
        logic [RECIP_W-1:0] res;
        case (base)
            5'd2:    res = 32'd2147483648;
            5'd3:    res = 32'd1431655765;
            5'd4:    res = 32'd1073741824;
            5'd5:    res = 32'd858993459;
            5'd6:    res = 32'd715827882;
            5'd7:    res = 32'd613566756;
            5'd8:    res = 32'd536870912;
            5'd9:    res = 32'd477218588;
            5'd10:   res = 32'd429496729;
            5'd11:   res = 32'd390451572;
            5'd12:   res = 32'd357913941;
            5'd13:   res = 32'd330382099;
            5'd14:   res = 32'd306783378;
            5'd15:   res = 32'd286331153;
            default: res = 32'd268435456;
        endcase
        return res;
    endfunction

endpackage

[src/rdc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_front: input acceptance and item queue
// Unpacks each input transfer, clamps the radix, flags a nonzero fraction
// and queues the item for the conversion engine.
// ----------------------------------------------------------------------------
module rdc_front
    import rdc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [RADIX_W-1:0]   radix,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 item_valid,
    input  logic                 item_ready,
    output rdc_item_t            item
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    rdc_item_t          queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    rdc_item_t          in_item;
    logic               push, pop;

    always_comb begin
        in_item.neg     = s_tdata[0];
        in_item.whole   = s_tdata[1 +: WHOLE_W];
        in_item.frac    = s_tdata[1 + WHOLE_W +: FRAC_W];
        in_item.base    = clamp_radix(radix);
        in_item.frac_nz = (s_tdata[1 + WHOLE_W +: FRAC_W] != '0);
    end

    assign s_tready   = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign item_valid = (fill_reg != '0);
    assign item       = queue_mem[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = FILL_W'(fill_reg + 1'b1);
        end else if (pop && !push) begin
            fill_next = FILL_W'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_item;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_ptr_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        PTR_W'(wr_ptr_reg - rd_ptr_reg) == PTR_W'(fill_reg))
        else $error("queue pointers disagree with fill");

endmodule

[src/rdc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_back: digit engine and output register
// Divides the integer part by the radix digit by digit (multiply, then fix)
// onto a digit stack, pops it out, then emits the point and fraction digits.
// ----------------------------------------------------------------------------
module rdc_back
    import rdc_pkg::*;
#(
    parameter int FRACTION_DIGITS  = FRACTION_DIGITS_DEF,
    parameter int WHOLE_DIGITS_MAX = WHOLE_DIGITS_MAX_DEF
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  rdc_item_t            item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]    m_tuser,
    output logic                 m_tlast
);

    localparam int CNT_W  = $clog2(WHOLE_DIGITS_MAX + 1);
    localparam int IDX_W  = $clog2(WHOLE_DIGITS_MAX);
    localparam int DONE_W = $clog2(FRACTION_DIGITS + 1);
    localparam int REM_W  = RADIX_W + 1;
    localparam int MQ_W   = WHOLE_W + RECIP_W;
    localparam int QD_W   = WHOLE_W + RADIX_W;
    localparam int FP_W   = FRAC_W + RADIX_W;

    back_state_t         state_reg, state_next;

    logic                neg_reg;
    logic                frac_nz_reg;
    logic [RADIX_W-1:0]  base_reg;
    logic [RECIP_W-1:0]  recip_reg;
    logic [WHOLE_W-1:0]  quot_reg;
    logic [WHOLE_W-1:0]  qest_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [DONE_W-1:0]   done_reg;
    logic [DIGIT_W-1:0]  digit_stack [WHOLE_DIGITS_MAX];

    logic                out_valid_reg;
    symbol_kind_t        out_kind_reg;
    logic [DIGIT_W-1:0]  out_digit_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                emit;
    symbol_kind_t        emit_kind;
    logic [DIGIT_W-1:0]  emit_digit;
    logic                emit_last;

    logic [MQ_W-1:0]     mq;
    logic [QD_W-1:0]     qd;
    logic [WHOLE_W-1:0]  rem_raw;
    logic [REM_W-1:0]    rem_small;
    logic [REM_W-1:0]    rem_fix;
    logic [WHOLE_W-1:0]  q_fix;
    logic [FP_W-1:0]     fp;
    logic [DIGIT_W-1:0]  frac_digit;
    logic [FRAC_W-1:0]   frac_rest;
    logic                frac_last;
    logic [DIGIT_W-1:0]  stack_top;
    logic                stack_room;

    assign out_free = !out_valid_reg || m_tready;

    // Quotient estimate by reciprocal, then one compare-and-subtract fix.
    assign mq        = MQ_W'(quot_reg) * MQ_W'(recip_reg);
    assign qd        = QD_W'(qest_reg) * QD_W'(base_reg);
    assign rem_raw   = quot_reg - qd[WHOLE_W-1:0];
    assign rem_small = rem_raw[REM_W-1:0];

    always_comb begin
        if (rem_small >= REM_W'(base_reg)) begin
            rem_fix = rem_small - REM_W'(base_reg);
            q_fix   = qest_reg + 1'b1;
        end else begin
            rem_fix = rem_small;
            q_fix   = qest_reg;
        end
    end

    assign fp         = FP_W'(frac_reg) * FP_W'(base_reg);
    assign frac_digit = fp[FRAC_W +: DIGIT_W];
    assign frac_rest  = fp[FRAC_W-1:0];
    assign frac_last  = (done_reg == DONE_W'(FRACTION_DIGITS - 1)) || (frac_rest == '0);

    assign stack_top  = digit_stack[IDX_W'(count_reg - 1'b1)];
    assign stack_room = (count_reg < CNT_W'(WHOLE_DIGITS_MAX));

    always_comb begin
        state_next = state_reg;
        item_ready = 1'b0;
        emit       = 1'b0;
        emit_kind  = KIND_DIGIT;
        emit_digit = '0;
        emit_last  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (!neg_reg) begin
                    state_next = ST_MUL;
                end else if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_MINUS;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_FIX;
            end
            ST_FIX: begin
                state_next = (q_fix == '0) ? ST_POP : ST_MUL;
            end
            ST_POP: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_digit = stack_top;
                    emit_last  = (count_reg == CNT_W'(1)) && !frac_nz_reg;
                    if (count_reg == CNT_W'(1)) begin
                        state_next = frac_nz_reg ? ST_POINT : ST_IDLE;
                    end
                end
            end
            ST_POINT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = KIND_POINT;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_digit = frac_digit;
                    emit_last  = frac_last;
                    if (frac_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (item_valid) begin
                        count_reg <= '0;
                        done_reg  <= '0;
                    end
                end
                ST_FIX: begin
                    if (stack_room) begin
                        count_reg <= CNT_W'(count_reg + 1'b1);
                    end
                end
                ST_POP: begin
                    if (out_free) begin
                        count_reg <= CNT_W'(count_reg - 1'b1);
                    end
                end
                ST_FRAC: begin
                    if (out_free) begin
                        done_reg <= DONE_W'(done_reg + 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working values and digit stack
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    neg_reg     <= item.neg;
                    quot_reg    <= item.whole;
                    frac_reg    <= item.frac;
                    base_reg    <= item.base;
                    frac_nz_reg <= item.frac_nz;
                    recip_reg   <= recip_of(item.base);
                end
            end
            ST_MUL: begin
                qest_reg <= mq[RECIP_W +: WHOLE_W];
            end
            ST_FIX: begin
                if (stack_room) begin
                    digit_stack[count_reg[IDX_W-1:0]] <= rem_fix[DIGIT_W-1:0];
                end
                quot_reg <= q_fix;
            end
            ST_FRAC: begin
                if (out_free) begin
                    frac_reg <= frac_rest;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: accept a new symbol whenever the slot drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg  <= emit_kind;
            out_digit_reg <= emit_digit;
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_digit_reg);
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_rem_below_base: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIX |-> rem_fix < REM_W'(base_reg))
        else $error("corrected remainder not below radix");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WHOLE_DIGITS_MAX))
        else $error("digit stack count above depth");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> count_reg == '0)
        else $error("digit stack not empty when idle");

    a_done_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg <= DONE_W'(FRACTION_DIGITS))
        else $error("too many fraction digits");

endmodule

[src/radix_digit_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter: signed fixed-point number to radix digit symbols
// Top level: radix register, input queue and digit engine.
// ----------------------------------------------------------------------------
// Each input transfer carries a sign, a 30-bit integer magnitude and a 0.32
// fraction; the block returns a stream of symbols (minus, digits, point) in the
// radix held in the configuration register (2 to 16, out-of-range values
// clamped), with tlast on the final symbol. The engine handles one number at a
// time: a load step, a sign step (taken whether or not a minus is emitted), a
// reciprocal multiply step and a remainder fix step per integer digit, a pop of
// the digit stack per integer digit, and, when the fraction is nonzero, a point
// step and a step per fraction digit. Output stalls hold the emitting steps.
// A two-entry input queue lets a following number be accepted while one is in
// conversion, and an output register decouples the result stream.
// ----------------------------------------------------------------------------
module radix_digit_converter
    import rdc_pkg::*;
#(
    parameter int FRACTION_DIGITS  = FRACTION_DIGITS_DEF,
    parameter int WHOLE_DIGITS_MAX = WHOLE_DIGITS_MAX_DEF
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RADIX_W-1:0]   cfg_data,   // radix
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // negative, whole_part, fraction_part, pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // digit_value, pad
    output logic [KIND_W-1:0]    m_tuser,    // symbol_kind
    output logic                 m_tlast
);

    logic [RADIX_W-1:0] radix_reg;
    logic               item_valid;
    logic               item_ready;
    rdc_item_t          item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            radix_reg <= cfg_data;
        end
    end

    rdc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .radix      (radix_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    rdc_back #(
        .FRACTION_DIGITS  (FRACTION_DIGITS),
        .WHOLE_DIGITS_MAX (WHOLE_DIGITS_MAX)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[sim/radix_digit_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_tb: self-checking bench for the radix digit converter
// Drives signed fixed-point numbers through the input stream under several
// radix settings, computes the expected symbol stream (minus, digits, point,
// fraction digits, tlast) in a scoreboard and compares every output transfer.
// ----------------------------------------------------------------------------
module radix_digit_converter_tb;
    import rdc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASE_ITEMS  = 22;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_CAP   = 50;

    typedef struct {
        symbol_kind_t         kind;
        logic [DIGIT_W-1:0]   digit;
        logic                 is_last;
    } symbol_rec_t;

    class radix_scoreboard;
        logic [RADIX_W-1:0] radix_reg;
        symbol_rec_t        symbol_q[$];
        int                 errors;

        function new();
            radix_reg = RADIX_RESET;
            errors    = 0;
        endfunction

        function void set_radix(logic [RADIX_W-1:0] value);
            radix_reg = value;
        endfunction

        function int outstanding();
            return symbol_q.size();
        endfunction

        task report_mismatch(string msg);
            if (errors < REPORT_CAP) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        // Expand one accepted number into the symbols it must produce.
        function void note_number(logic neg, logic [WHOLE_W-1:0] whole,
                                  logic [FRAC_W-1:0] frac);
            logic [RADIX_W-1:0] base;
            logic [WHOLE_W-1:0] quot;
            logic [FRAC_W-1:0]  rem_frac;
            logic [63:0]        prod;
            logic [DIGIT_W-1:0] digit_stack[$];
            symbol_rec_t        syms[$];
            int                 done;
            if (radix_reg < RADIX_MIN) begin
                base = RADIX_MIN;
            end else if (radix_reg > RADIX_MAX) begin
                base = RADIX_MAX;
            end else begin
                base = radix_reg;
            end
            if (neg) begin
                syms.push_back('{kind: KIND_MINUS, digit: '0, is_last: 1'b0});
            end
            // Push least significant first; zero still yields one digit.
            quot = whole;
            do begin
                digit_stack.push_back(DIGIT_W'(quot % WHOLE_W'(base)));
                quot = quot / WHOLE_W'(base);
            end while (quot != 0);
            while (digit_stack.size() > 0) begin
                syms.push_back('{kind: KIND_DIGIT, digit: digit_stack.pop_back(),
                                 is_last: 1'b0});
            end
            if (frac != 0) begin
                syms.push_back('{kind: KIND_POINT, digit: '0, is_last: 1'b0});
                rem_frac = frac;
                done     = 0;
                while (done < FRACTION_DIGITS_DEF && rem_frac != 0) begin
                    prod     = 64'(rem_frac) * 64'(base);
                    syms.push_back('{kind: KIND_DIGIT, digit: prod[35:32],
                                     is_last: 1'b0});
                    rem_frac = prod[31:0];
                    done++;
                end
            end
            syms[syms.size()-1].is_last = 1'b1;
            foreach (syms[i]) symbol_q.push_back(syms[i]);
        endfunction

        task check_symbol(symbol_kind_t kind, logic [DIGIT_W-1:0] digit,
                          logic is_last);
            symbol_rec_t want;
            if (symbol_q.size() == 0) begin
                report_mismatch($sformatf("unexpected symbol kind=%0d digit=%0d last=%0b",
                                          kind, digit, is_last));
                return;
            end
            want = symbol_q.pop_front();
            if (kind !== want.kind || digit !== want.digit || is_last !== want.is_last)
            begin
                report_mismatch($sformatf(
                    "kind=%0d digit=%0d last=%0b, wanted kind=%0d digit=%0d last=%0b",
                    kind, digit, is_last, want.kind, want.digit, want.is_last));
            end
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [RADIX_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;

    radix_scoreboard sb;
    int              cycle_count;
    int              rx_hold;
    bit              calm;

    radix_digit_converter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Output monitor: sample each transfer at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_symbol(symbol_kind_t'(m_tuser), m_tdata[DIGIT_W-1:0], m_tlast);
        end
    end

    // Receiver: short stall bursts, quiet stretches, and the long hold-off.
    initial begin
        int stall_left;
        int quiet_left;
        int roll;
        m_tready   = 1'b0;
        stall_left = 0;
        quiet_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (quiet_left > 0) begin
                    quiet_left--;
                end else if (!calm) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 15) begin
                        stall_left = $urandom_range(1, 4);
                    end else if (roll < 17) begin
                        quiet_left = 40;
                    end
                end
            end
        end
    end

    task automatic send_number(logic neg, logic [WHOLE_W-1:0] whole,
                               logic [FRAC_W-1:0] frac);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, frac, whole, neg};
        do @(posedge aclk); while (!s_tready);
        sb.note_number(neg, whole, frac);
    endtask

    task automatic sender_idle(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
    endtask

    // Drop the offer first so the last number is not taken twice.
    task automatic wait_drained();
        sender_idle(1);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic write_radix(logic [RADIX_W-1:0] value);
        @(negedge aclk);
        s_tvalid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_radix(value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random();
        logic               neg;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        int                 pick;
        neg  = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        case (pick)
            0:          whole = '0;
            1, 2, 3:    whole = WHOLE_W'($urandom_range(0, 255));
            4, 5, 6, 7: whole = WHOLE_W'($urandom_range(0, 1000000000));
            default:    whole = WHOLE_W'($urandom);
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: frac = '0;
            3, 4:    frac = $urandom & 32'hFFF0_0000;
            5:       frac = 32'h1 << $urandom_range(0, 31);
            default: frac = $urandom;
        endcase
        if (!calm && $urandom_range(0, 99) < 25) begin
            sender_idle($urandom_range(1, 4));
        end
        send_number(neg, whole, frac);
    endtask

    initial begin
        logic [RADIX_W-1:0] radix_plan[10];
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        rx_hold     = 0;
        calm        = 1'b0;
        sb          = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset radix first, then the range ends and clamping.
        send_number(1'b0, '0, '0);
        send_number(1'b1, '0, '0);
        send_number(1'b1, '1, '1);
        send_number(1'b0, WHOLE_W'(1000000000), '0);
        send_number(1'b0, WHOLE_W'(12345), 32'h8000_0000);
        send_number(1'b1, WHOLE_W'(7), 32'h0000_0001);
        send_number(1'b0, WHOLE_W'(1), 32'h4000_0000);
        wait_drained();
        write_radix(RADIX_W'(2));
        send_number(1'b1, '1, '1);
        send_number(1'b0, '0, 32'h8000_0000);
        wait_drained();
        write_radix(RADIX_W'(16));
        send_number(1'b0, '1, 32'hFFFF_FFFF);
        send_number(1'b1, WHOLE_W'(16), 32'h0F00_0000);
        wait_drained();
        write_radix(RADIX_W'(0));
        send_number(1'b0, WHOLE_W'(5), 32'hC000_0000);
        wait_drained();
        write_radix(RADIX_W'(1));
        send_number(1'b1, WHOLE_W'(6), 32'h2000_0000);
        wait_drained();
        write_radix(RADIX_W'(17));
        send_number(1'b0, WHOLE_W'(255), 32'h1234_5678);
        wait_drained();
        write_radix(RADIX_W'(31));
        send_number(1'b1, WHOLE_W'(4096), 32'hF000_0000);

        // Random phases, each under its own radix setting.
        radix_plan = '{RADIX_W'(10), RADIX_W'(2), RADIX_W'(16), RADIX_W'(31),
                       RADIX_W'(0), RADIX_W'(7), RADIX_W'(3),
                       RADIX_W'($urandom_range(0, 31)), RADIX_W'(12), RADIX_W'(10)};
        foreach (radix_plan[p]) begin
            sender_idle(1);
            wait_drained();
            write_radix(radix_plan[p]);
            calm = (p == $size(radix_plan) - 1);
            // Receiver blocks for a long stretch: input must back up.
            if (p == 2) rx_hold = HOLD_CYCLES;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 4 && i == PHASE_ITEMS / 2) begin
                    sender_idle(1);
                    wait_drained();
                end
                send_random();
            end
        end

        sender_idle(1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
